### hdl/core_allocation_bitmap_index_unit_assert.svh
// assertion macros for the core allocation bitmap index unit
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef CORE_ALLOCATION_BITMAP_INDEX_UNIT_ASSERT_SVH
`define CORE_ALLOCATION_BITMAP_INDEX_UNIT_ASSERT_SVH

// a holds at an edge implies b holds at the same edge
`define CABI_AST_IMPLY(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("cabi check failed");

// a holds at an edge implies b holds at the next edge
`define CABI_AST_NEXT(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("cabi check failed");

`endif

### hdl/cabi_pkg.sv
// shared types, codes and defaults of the core allocation bitmap index unit
// no dependencies
package cabi_pkg;

    localparam int GROUPS_DEF    = 16;
    localparam int CORE_BITS_DEF = 4096;
    localparam int WORD_W        = 16;
    localparam int BASE_W        = 18;
    localparam logic [BASE_W-1:0] BASE_CAP = 18'h20000;

    localparam logic [2:0] CMD_LOAD      = 3'd0;
    localparam logic [2:0] CMD_TEST_CORE = 3'd1;
    localparam logic [2:0] CMD_SET_CORE  = 3'd2;
    localparam logic [2:0] CMD_TEST_NODE = 3'd3;
    localparam logic [2:0] CMD_SET_NODE  = 3'd4;
    localparam logic [2:0] CMD_SHAPE     = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SOCKET   = 3'd1;
    localparam logic [2:0] ST_CORE     = 3'd2;
    localparam logic [2:0] ST_BOUND    = 3'd3;
    localparam logic [2:0] ST_NO_NODE  = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] node_index;
        logic [15:0] socket_index;
        logic [15:0] core_index;
        logic [3:0]  group_slot;
        logic [6:0]  group_sockets;
        logic [8:0]  group_cores;
        logic [15:0] group_repeats;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic        bit_value;
        logic [11:0] bit_offset;
        logic [6:0]  node_sockets;
        logic [8:0]  node_cores;
    } t_out;

    typedef struct packed {
        logic        en;
        logic [3:0]  slot;
        logic [6:0]  sockets;
        logic [8:0]  cores;
        logic [15:0] repeats;
    } t_walk_load;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [6:0]        sockets;
        logic [8:0]        cores;
        logic [15:0]       per;
        logic [BASE_W-1:0] base;
    } t_walk_res;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_BREAD,
        S_BMOD,
        S_NREAD,
        S_NMOD,
        S_DONE
    } t_state;

endpackage

### hdl/cabi_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module cabi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cabi_walk.sv
// layout group table and the node walk over it, one group per cycle
// depends on cabi_pkg
module cabi_walk import cabi_pkg::*; #(
    parameter int GROUPS = GROUPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_walk_load  i_load,
    input  logic        i_start,
    input  logic [15:0] i_node,
    output t_walk_res   o_res
);

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic [6:0]        r_soc [GROUPS];
    logic [8:0]        r_cor [GROUPS];
    logic [15:0]       r_rep [GROUPS];
    logic [15:0]       r_per [GROUPS];
    logic              r_busy;
    logic [GW-1:0]     r_g;
    logic [BASE_W-1:0] r_acc;
    logic [15:0]       r_rem;
    t_walk_res         r_res;

    logic [15:0]       rep;
    logic [15:0]       per;
    logic              take;
    logic [31:0]       prod;
    logic [32:0]       sum;
    logic [BASE_W-1:0] sat;

    always_comb begin
        rep  = r_rep[r_g];
        per  = r_per[r_g];
        take = rep <= r_rem;
        prod = per * (take ? rep : r_rem);
        sum  = 33'(r_acc) + 33'(prod);
        sat  = (sum > 33'(BASE_CAP)) ? BASE_CAP : BASE_W'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_res  <= '0;
            r_g    <= '0;
            r_acc  <= '0;
            r_rem  <= '0;
            for (int i = 0; i < GROUPS; i++) begin
                r_soc[i] <= '0;
                r_cor[i] <= '0;
                r_rep[i] <= '0;
                r_per[i] <= '0;
            end
        end else begin
            r_res.done <= 1'b0;
            if (i_load.en && (32'(i_load.slot) < GROUPS)) begin
                r_soc[GW'(i_load.slot)] <= i_load.sockets;
                r_cor[GW'(i_load.slot)] <= i_load.cores;
                r_rep[GW'(i_load.slot)] <= i_load.repeats;
                r_per[GW'(i_load.slot)] <= 16'(i_load.sockets * i_load.cores);
            end
            if (i_start) begin
                r_busy <= 1'b1;
                r_g    <= '0;
                r_acc  <= '0;
                r_rem  <= i_node;
            end else if (r_busy) begin
                if (take) begin
                    r_acc <= sat;
                    r_rem <= r_rem - rep;
                    if (r_g == GW'(GROUPS - 1)) begin
                        r_busy <= 1'b0;
                        r_res  <= '{done: 1'b1, found: 1'b0, sockets: '0, cores: '0,
                                   per: '0, base: '0};
                    end else begin
                        r_g <= r_g + 1'b1;
                    end
                end else begin
                    // node lies inside this group
                    r_busy <= 1'b0;
                    r_res  <= '{done: 1'b1, found: 1'b1, sockets: r_soc[r_g],
                               cores: r_cor[r_g], per: per, base: sat};
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

### hdl/core_allocation_bitmap_index_unit.sv
// core allocation bitmap index unit: command sequencer and bitmap read-modify-write
// depends on cabi_pkg, cabi_walk, cabi_ram and the assertion macro header
//
// usage: one command word enters on the input channel (i_in_valid / o_in_stall),
// one result word leaves on the output channel (o_out_valid / i_out_stall).
// the bitmap size register is written through i_cfg_we / i_cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
// lookups walk the layout table one group per cycle. node test/set then sweeps
// the node's bitmap words, reading each 16-bit word, then modifying it and
// writing it back, as the bitmap ram has registered read data.
// one command is in work at a time; the next command is taken as soon as the
// result is placed in the output register, even while that result is stalled.
// a finished result waits in its state only while the output register is full
// and stalled. after reset the bitmap ram is swept to zero, one word a cycle,
// over CORE_BITS/16 words (256 at the default size); o_in_stall stays high
// until done. reset also clears the layout table and the bitmap size register.
module core_allocation_bitmap_index_unit import cabi_pkg::*; #(
    parameter int GROUPS    = GROUPS_DEF,
    parameter int CORE_BITS = CORE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data
);

    localparam int DEPTH = CORE_BITS / WORD_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW    = AW + 4;

    t_state      r_state, n_state;
    logic [12:0] r_size;
    t_in         r_item;
    t_out        r_res, n_res;
    t_out        r_out;
    logic        r_out_valid;
    logic [AW-1:0] r_caddr;
    logic [AW-1:0] r_addr, n_addr;
    logic [OW-1:0] r_off, n_off;
    logic [OW-1:0] r_hi, n_hi;

    t_walk_load  walk_load;
    t_walk_res   walk;
    logic        in_acc;
    logic        out_free;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [16:0] lim;
    logic [25:0] off_full;
    logic [25:0] node_end;
    logic        is_core, is_node;
    logic        core_go, node_go;
    logic        sock_ok, core_ok, off_ok, node_ok;
    logic        last_word;
    logic [WORD_W-1:0] mask;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign walk_load = '{en: in_acc && (i_in.cmd == CMD_LOAD), slot: i_in.group_slot,
                         sockets: i_in.group_sockets, cores: i_in.group_cores,
                         repeats: i_in.group_repeats};

    // only the lookup commands start a walk
    cabi_walk #(.GROUPS(GROUPS)) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (walk_load),
        .i_start (in_acc && (i_in.cmd != CMD_LOAD) && (i_in.cmd <= CMD_SHAPE)),
        .i_node  (i_in.node_index),
        .o_res   (walk)
    );

    cabi_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // range checks on the walk result, plus the last-word test and bit mask of the node sweep
    always_comb begin
        lim      = ({4'b0, r_size} > 17'(CORE_BITS)) ? 17'(CORE_BITS) : {4'b0, r_size};
        is_core  = (r_item.cmd == CMD_TEST_CORE) || (r_item.cmd == CMD_SET_CORE);
        is_node  = (r_item.cmd == CMD_TEST_NODE) || (r_item.cmd == CMD_SET_NODE);
        sock_ok  = r_item.socket_index < {9'b0, walk.sockets};
        core_ok  = r_item.core_index < {7'b0, walk.cores};
        off_full = 26'(walk.base) + 26'(walk.cores * r_item.socket_index)
                   + 26'(r_item.core_index);
        off_ok   = off_full < 26'(lim);
        node_end = 26'(walk.base) + 26'(walk.per);
        node_ok  = node_end <= 26'(lim);
        core_go  = is_core && walk.found && sock_ok && core_ok && off_ok;
        node_go  = is_node && walk.found && (walk.per != '0) && node_ok;
        last_word = r_addr == AW'(r_hi >> 4);
        for (int j = 0; j < WORD_W; j++) begin
            mask[j] = ({r_addr, 4'(j)} >= r_off) && ({r_addr, 4'(j)} <= r_hi);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_caddr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if ((i_in.cmd == CMD_LOAD) || (i_in.cmd > CMD_SHAPE)) n_state = S_DONE;
                    else n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk.done) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (core_go) n_state = S_BREAD;
                else if (node_go) n_state = S_NREAD;
                else n_state = S_DONE;
            end
            S_BREAD: n_state = S_BMOD;
            S_BMOD:  n_state = S_DONE;
            S_NREAD: n_state = S_NMOD;
            S_NMOD: begin
                n_state = last_word ? S_DONE : S_NREAD;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_res     = r_res;
        n_addr    = r_addr;
        n_off     = r_off;
        n_hi      = r_hi;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = ram_rdata;
        ram_raddr = r_addr;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_caddr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                n_res = '0;
            end
            S_CHECK: begin
                if (is_core) begin
                    if (!walk.found) n_res.status = ST_NO_NODE;
                    else if (!sock_ok) n_res.status = ST_SOCKET;
                    else if (!core_ok) n_res.status = ST_CORE;
                    else if (!off_ok) n_res.status = ST_BOUND;
                    else begin
                        n_off            = OW'(off_full);
                        n_res.bit_offset = 12'(off_full);
                    end
                end else if (is_node) begin
                    if (!walk.found || (walk.per == '0)) n_res.status = ST_NO_NODE;
                    else if (!node_ok) n_res.status = ST_BOUND;
                    else begin
                        n_off            = OW'(walk.base);
                        n_hi             = OW'(node_end - 26'd1);
                        n_addr           = AW'(walk.base >> 4);
                        n_res.bit_offset = 12'(walk.base);
                    end
                end else begin
                    if (walk.found) begin
                        n_res.node_sockets = walk.sockets;
                        n_res.node_cores   = walk.cores;
                    end else begin
                        n_res.status = ST_NO_NODE;
                    end
                end
            end
            S_BREAD: begin
                ram_raddr = AW'(r_off >> 4);
            end
            S_BMOD: begin
                ram_waddr = AW'(r_off >> 4);
                if (r_item.cmd == CMD_TEST_CORE) begin
                    n_res.bit_value = ram_rdata[r_off[3:0]];
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (WORD_W'(1) << r_off[3:0]);
                end
            end
            S_NMOD: begin
                if (r_item.cmd == CMD_TEST_NODE) begin
                    n_res.bit_value = r_res.bit_value | (|(ram_rdata & mask));
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | mask;
                end
                n_addr = r_addr + 1'b1;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_size      <= '0;
            r_caddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (r_state == S_CLEAR) begin
                r_caddr <= r_caddr + 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_addr <= n_addr;
        r_off  <= n_off;
        r_hi   <= n_hi;
        if (in_acc) begin
            r_item <= i_in;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`include "core_allocation_bitmap_index_unit_assert.svh"

    // no word is taken while the bitmap is still being cleared
    `CABI_AST_IMPLY(a_clear_stall, r_state == S_CLEAR, o_in_stall)
    // the walk only finishes while the sequencer waits for it
    `CABI_AST_IMPLY(a_walk_done, walk.done, r_state == S_WALK)
    // bitmap writes outside the clear sweep come only from the modify steps
    `CABI_AST_IMPLY(a_ram_write, ram_we && (r_state != S_CLEAR),
                    (r_state == S_BMOD) || (r_state == S_NMOD))
    // a result moves into the output register only when it is free
    `CABI_AST_NEXT(a_out_load, (r_state == S_DONE) && out_free, o_out_valid)

endmodule
